/* src/branch_bound_frontier_queue_assert.svh */
// Assertion macros for the branch-and-bound frontier queue.
`ifndef BRANCH_BOUND_FRONTIER_QUEUE_ASSERT_SVH
`define BRANCH_BOUND_FRONTIER_QUEUE_ASSERT_SVH
`ifndef SYNTH
`define BBFQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BBFQ_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBFQ_ASSERT(label, clk, rst, prop, msg)
`define BBFQ_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* src/bbfq_pkg.sv */
// Shared types and constants for the branch-and-bound frontier queue.
`default_nettype none
package bbfq_pkg;
   localparam int unsigned QUEUE_DEPTH = 256;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [15:0] FIRST_SWITCH_RST = 16'd20;
   localparam logic [15:0] PRIO_PHASE_RST   = 16'd733;
   localparam logic [15:0] DEPTH_PHASE_RST  = 16'd97;
   localparam logic [15:0] ITER_LIMIT_RST   = 16'd8000;

   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_OFFER  = 2'd2;
   localparam logic [1:0] OP_EXPEND = 2'd3;

   localparam logic [2:0] ST_EXPAND  = 3'd0;
   localparam logic [2:0] ST_DONE    = 3'd1;
   localparam logic [2:0] ST_QUEUED  = 3'd2;
   localparam logic [2:0] ST_DROPPED = 3'd3;
   localparam logic [2:0] ST_NEWBEST = 3'd4;
   localparam logic [2:0] ST_FULL    = 3'd5;
   localparam logic [2:0] ST_ACK     = 3'd6;

   localparam logic [1:0] CSR_FIRST = 2'd0;
   localparam logic [1:0] CSR_PRIO  = 2'd1;
   localparam logic [1:0] CSR_DEPTH = 2'd2;
   localparam logic [1:0] CSR_LIMIT = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] node_id;
      logic [63:0] lower_bound;
      logic        solution_node;
      logic [63:0] path_cost;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] out_node_id;
      logic [63:0] out_lower_bound;
      logic [15:0] best_node_id;
      logic [63:0] best_cost;
      logic        has_best;
      logic        priority_active;
   } rsp_type;

   typedef struct packed {
      logic [15:0] handle;
      logic [63:0] bound;
   } entry_type;

   // Row command, same for every cell in a cycle.
   typedef enum logic [2:0] {
      CMD_HOLD, CMD_LOAD, CMD_PUSH, CMD_INSERT, CMD_SHIFT, CMD_SORT_EVEN, CMD_SORT_ODD
   } cmd_type;

   typedef struct packed {
      cmd_type   cmd;
      entry_type data;
   } row_ctl_type;
endpackage
`default_nettype wire

/* src/bbfq_cell.sv */
// One queue cell: holds an entry and trades it with its neighbors.
`default_nettype none
module bbfq_cell (
   input  wire logic                  clock,
   input  wire logic                  even_pos,
   input  wire bbfq_pkg::row_ctl_type ctl,
   input  wire bbfq_pkg::entry_type   left_entry,
   input  wire logic                  left_ins,
   input  wire logic                  left_live,
   input  wire bbfq_pkg::entry_type   right_entry,
   input  wire logic                  right_live,
   input  wire logic                  live,
   output bbfq_pkg::entry_type        entry,
   output logic                       ins
);
   import bbfq_pkg::*;
   entry_type entry_ff, entry_in;
   logic pair_lo, pair_hi, odd_sort;

   assign entry = entry_ff;
   // Insert point: the row is sorted, so every cell from the first bound not
   // below the new one onward flags it on its own.
   assign ins = !live | (entry_ff.bound >= ctl.data.bound);
   assign odd_sort = (ctl.cmd == CMD_SORT_ODD);
   assign pair_lo = (even_pos ^ odd_sort);

   always_comb begin
      entry_in = entry_ff;
      case (ctl.cmd)
         CMD_LOAD:   entry_in = ctl.data;
         CMD_PUSH:   entry_in = left_live ? left_entry : ctl.data;
         CMD_INSERT: begin
            if (left_ins) entry_in = left_entry;
            else if (ins) entry_in = ctl.data;
         end
         CMD_SHIFT:  entry_in = right_entry;
         CMD_SORT_EVEN, CMD_SORT_ODD: begin
            // Swap only strictly out-of-order live pairs: keeps it stable.
            if (pair_lo) begin
               if (right_live && entry_ff.bound > right_entry.bound) entry_in = right_entry;
            end else begin
               if (live && left_live && left_entry.bound > entry_ff.bound)
                  entry_in = left_entry;
            end
         end
         default:    entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end
endmodule
`default_nettype wire

/* src/bbfq_ctrl.sv */
// Sequencer: search state, mode countdowns and row commands.
`default_nettype none
`include "branch_bound_frontier_queue_assert.svh"
module bbfq_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire bbfq_pkg::req_type       req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output bbfq_pkg::rsp_type            rsp_data,
   input  wire logic                    csr_write,
   input  wire logic [1:0]              csr_index,
   input  wire logic [15:0]             csr_data,
   input  wire bbfq_pkg::entry_type     head,
   input  wire logic                    tail_ins,
   output bbfq_pkg::row_ctl_type        ctl,
   output logic [bbfq_pkg::CNT_W-1:0]   count
);
   import bbfq_pkg::*;
   typedef enum logic [1:0] {S_IDLE, S_POP, S_SORT, S_OUT} state_type;

   state_type state_ff;
   logic [CNT_W-1:0] count_ff, sort_ff;
   logic [63:0] upper_ff;
   logic [15:0] best_id_ff, countdown_ff, exp_ff;
   logic best_valid_ff, sorted_ff, finished_ff, odd_ff;
   logic [15:0] first_ff, prio_ff, depth_ff, limit_ff;
   logic [2:0] status_ff;
   logic [15:0] out_id_ff;
   logic [63:0] out_lb_ff;
   logic [15:0] cd_dec, exp_inc;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   // Search state only moves outside S_OUT, so show it directly.
   assign rsp_data = '{status: status_ff, out_node_id: out_id_ff,
                       out_lower_bound: out_lb_ff, best_node_id: best_id_ff,
                       best_cost: upper_ff, has_best: best_valid_ff,
                       priority_active: sorted_ff};
   assign count = count_ff;
   assign cd_dec = countdown_ff - 16'd1;
   assign exp_inc = (exp_ff == 16'hFFFF) ? exp_ff : exp_ff + 16'd1;

   // Drive the row for this cycle.
   always_comb begin
      ctl.cmd = CMD_HOLD;
      ctl.data.handle = req_data.node_id;
      ctl.data.bound = req_data.lower_bound;
      if (state_ff == S_IDLE && req_valid) begin
         if (req_data.opcode == OP_START) ctl.cmd = CMD_LOAD;
         else if (!finished_ff && req_data.opcode == OP_OFFER && !req_data.solution_node &&
                  req_data.lower_bound < upper_ff && count_ff < CNT_W'(QUEUE_DEPTH))
            ctl.cmd = sorted_ff ? CMD_INSERT : CMD_PUSH;
      end else if (state_ff == S_POP && count_ff != '0) begin
         ctl.cmd = CMD_SHIFT;
      end else if (state_ff == S_SORT) begin
         ctl.cmd = odd_ff ? CMD_SORT_ODD : CMD_SORT_EVEN;
      end
   end

   // Hold state, registers and the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         upper_ff <= '1;
         best_id_ff <= '0;
         best_valid_ff <= 1'b0;
         sorted_ff <= 1'b0;
         countdown_ff <= '0;
         exp_ff <= '0;
         finished_ff <= 1'b0;
         first_ff <= FIRST_SWITCH_RST;
         prio_ff <= PRIO_PHASE_RST;
         depth_ff <= DEPTH_PHASE_RST;
         limit_ff <= ITER_LIMIT_RST;
         sort_ff <= '0;
         odd_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_FIRST: first_ff <= csr_data;
               CSR_PRIO:  prio_ff <= csr_data;
               CSR_DEPTH: depth_ff <= csr_data;
               CSR_LIMIT: limit_ff <= csr_data;
               default:   first_ff <= first_ff;
            endcase
         end
         case (state_ff)
            S_IDLE: if (req_valid) begin
               out_id_ff <= '0;
               out_lb_ff <= '0;
               if (req_data.opcode == OP_START) begin
                  status_ff <= ST_ACK;
                  state_ff <= S_OUT;
                  count_ff <= CNT_W'(1);
                  upper_ff <= '1;
                  best_id_ff <= '0;
                  best_valid_ff <= 1'b0;
                  sorted_ff <= 1'b0;
                  countdown_ff <= '0;
                  exp_ff <= '0;
                  finished_ff <= 1'b0;
               end else if (finished_ff) begin
                  status_ff <= ST_DONE;
                  state_ff <= S_OUT;
               end else if (req_data.opcode == OP_POP) begin
                  state_ff <= S_POP;
               end else if (req_data.opcode == OP_OFFER) begin
                  state_ff <= S_OUT;
                  if (req_data.solution_node) begin
                     if (req_data.path_cost < upper_ff) begin
                        upper_ff <= req_data.path_cost;
                        if (!best_valid_ff) countdown_ff <= first_ff;
                        best_valid_ff <= 1'b1;
                        best_id_ff <= req_data.node_id;
                        status_ff <= ST_NEWBEST;
                     end else status_ff <= ST_DROPPED;
                  end else if (req_data.lower_bound >= upper_ff) begin
                     status_ff <= ST_DROPPED;
                  end else if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                     status_ff <= ST_FULL;
                  end else begin
                     count_ff <= count_ff + CNT_W'(1);
                     status_ff <= ST_QUEUED;
                  end
               end else begin
                  exp_ff <= exp_inc;
                  if (best_valid_ff) begin
                     if (cd_dec == '0) begin
                        sorted_ff <= !sorted_ff;
                        if (!sorted_ff) begin
                           countdown_ff <= prio_ff;
                           sort_ff <= count_ff;
                           odd_ff <= 1'b0;
                           state_ff <= S_SORT;
                        end else begin
                           countdown_ff <= depth_ff;
                           state_ff <= S_OUT;
                        end
                     end else begin
                        countdown_ff <= cd_dec;
                        state_ff <= S_OUT;
                     end
                     if (exp_inc > limit_ff) begin
                        finished_ff <= 1'b1;
                        status_ff <= ST_DONE;
                     end else status_ff <= ST_ACK;
                  end else begin
                     status_ff <= ST_ACK;
                     state_ff <= S_OUT;
                  end
               end
            end
            S_POP: begin
               if (count_ff == '0) begin
                  finished_ff <= 1'b1;
                  status_ff <= ST_DONE;
                  state_ff <= S_OUT;
               end else begin
                  count_ff <= count_ff - CNT_W'(1);
                  if (head.bound < upper_ff) begin
                     status_ff <= ST_EXPAND;
                     out_id_ff <= head.handle;
                     out_lb_ff <= head.bound;
                     state_ff <= S_OUT;
                  end
               end
            end
            S_SORT: begin
               // Odd-even transposition: count passes sort the row.
               odd_ff <= !odd_ff;
               if (sort_ff == '0) state_ff <= S_OUT;
               else sort_ff <= sort_ff - CNT_W'(1);
            end
            S_OUT: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `BBFQ_ASSERT(a_count_max, clock, reset, count_ff <= CNT_W'(QUEUE_DEPTH),
      "queue count past depth")
   `BBFQ_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid,
      "response lost")
   `BBFQ_ASSERT(a_one_side, clock, reset, !(req_ready && rsp_valid),
      "accepting while response pending")
   `BBFQ_ASSERT(a_tail_open, clock, reset, (ctl.cmd == CMD_INSERT) |-> tail_ins,
      "sorted insert with no room at the tail")
endmodule
`default_nettype wire

/* src/branch_bound_frontier_queue.sv */
// Top level of the branch-and-bound frontier queue.
// Usage: one request on req_* (opcode start, pop, offer, end of expansion)
// gives exactly one response on rsp_*. The block takes one request at a time:
// req_ready is low from accept until the response is taken.
// Start, offer and a plain end of expansion: the response is valid in the
// cycle after accept.
// Pop shifts the cell row toward the head one entry a cycle, dropping pruned
// entries, until an unpruned entry is out or the queue is empty.
// End of expansion that enters priority mode runs an odd-even transposition
// sort across the row, queue count + 1 passes, one per cycle, then answers.
// Offer inserts in place in priority mode, every cell comparing its bound in
// parallel; otherwise it pushes the new entry at the head.
// The next request is taken from the cycle after the response is accepted.
// csr_* writes the four countdown and limit registers at any edge outside reset.
// Reset (synchronous) empties the queue, clears the best solution and
// restores register defaults. If rsp_ready stays low the response holds
// and no new request is taken.
`default_nettype none
module branch_bound_frontier_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire bbfq_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bbfq_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_data
);
   import bbfq_pkg::*;
   row_ctl_type ctl;
   logic [CNT_W-1:0] count;
   entry_type ents [QUEUE_DEPTH];
   logic ins [QUEUE_DEPTH];
   logic live [QUEUE_DEPTH];

   bbfq_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_write, .csr_index, .csr_data,
      .head(ents[0]), .tail_ins(ins[QUEUE_DEPTH-1]), .ctl, .count
   );

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type le, re;
      logic li, ll, rl;
      assign live[i] = CNT_W'(i) < count;
      if (i == 0) begin : g_first
         assign le = ctl.data;
         assign li = 1'b0;
         assign ll = 1'b0;
      end else begin : g_mid
         assign le = ents[i-1];
         assign li = ins[i-1];
         assign ll = live[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign re = ents[i];
         assign rl = 1'b0;
      end else begin : g_next
         assign re = ents[i+1];
         assign rl = live[i+1];
      end
      bbfq_cell u_cell (
         .clock, .even_pos(i % 2 == 0), .ctl,
         .left_entry(le), .left_ins(li), .left_live(ll),
         .right_entry(re), .right_live(rl), .live(live[i]),
         .entry(ents[i]), .ins(ins[i])
      );
   end
endmodule
`default_nettype wire
